@@ hdl/bpp_pkg.sv @@
// ============================================================================
// bpp_pkg
// shared types and constants of the biosignal packet parser
// ============================================================================
package bpp_pkg;

    // default geometry of one packet
    localparam int EEG_CHANNELS_DEF = 8;
    localparam int ACCEL_AXES_DEF   = 3;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 3;
    localparam int VALUE_W  = 24;
    localparam int ACCEL_W  = 16;
    localparam int POS_W    = 2;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARKER = 1'b1;
    localparam logic [BYTE_W-1:0]    END_MARKER_RST    = 8'd192;
    localparam logic [BYTE_W-1:0]    HEADER_MARKER_RST = 8'd160;

    // result kinds
    localparam logic KIND_EEG   = 1'b0;
    localparam logic KIND_ACCEL = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_COUNTER = 3'd2,
        PH_EEG     = 3'd3,
        PH_ACCEL   = 3'd4
    } t_phase;

    typedef struct packed {
        logic                       sample_kind;
        logic [IDX_W-1:0]           channel_index;
        logic signed [VALUE_W-1:0]  sample_value;
        logic [BYTE_W-1:0]          sample_number;
        logic                       packet_last;
    } t_result;

endpackage

@@ hdl/bpp_if.sv @@
// ============================================================================
// bpp_byte_if / bpp_sample_if
// valid/ready channels for serial bytes in and decoded samples out
// ============================================================================
interface bpp_byte_if
    import bpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bpp_sample_if
    import bpp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      sample_kind;
    logic [IDX_W-1:0]          channel_index;
    logic signed [VALUE_W-1:0] sample_value;
    logic [BYTE_W-1:0]         sample_number;
    logic                      packet_last;

    modport source (output valid, output sample_kind, output channel_index,
                    output sample_value, output sample_number, output packet_last,
                    input ready);
    modport sink   (input valid, input sample_kind, input channel_index,
                    input sample_value, input sample_number, input packet_last,
                    output ready);
endinterface

@@ hdl/bpp_parser.sv @@
// ============================================================================
// bpp_parser
// packet state machine and value assembly, one byte per accepted beat
// ============================================================================
module bpp_parser
    import bpp_pkg::*;
#(
    parameter int EEG_CHANNELS = EEG_CHANNELS_DEF,
    parameter int ACCEL_AXES   = ACCEL_AXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_res_valid,
    output t_result              o_res
);

    localparam logic [IDX_W-1:0] EEG_LAST_IDX   = IDX_W'(EEG_CHANNELS - 1);
    localparam logic [IDX_W-1:0] ACCEL_LAST_IDX = IDX_W'(ACCEL_AXES - 1);
    localparam logic [POS_W-1:0] EEG_LAST_POS   = POS_W'(2);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_byte_pos, n_byte_pos;
    logic [IDX_W-1:0]   r_value_idx, n_value_idx;
    logic [ACCEL_W-1:0] r_partial, n_partial;
    logic [BYTE_W-1:0]  r_counter, n_counter;
    logic [BYTE_W-1:0]  r_end_marker;
    logic [BYTE_W-1:0]  r_header_marker;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_value_idx = r_value_idx;
        n_partial   = r_partial;
        n_counter   = r_counter;
        case (r_phase)
            PH_HEADER: begin
                n_phase = (i_data_byte == r_header_marker) ? PH_COUNTER : PH_HUNT;
            end
            PH_COUNTER: begin
                n_counter   = i_data_byte;
                n_value_idx = '0;
                n_byte_pos  = '0;
                n_phase     = PH_EEG;
            end
            PH_EEG: begin
                if (r_byte_pos < EEG_LAST_POS) begin
                    n_partial  = {r_partial[BYTE_W-1:0], i_data_byte};
                    n_byte_pos = r_byte_pos + POS_W'(1);
                end else begin
                    n_byte_pos = '0;
                    n_partial  = '0;
                    if (r_value_idx == EEG_LAST_IDX) begin
                        n_value_idx = '0;
                        n_phase     = PH_ACCEL;
                    end else begin
                        n_value_idx = r_value_idx + IDX_W'(1);
                    end
                end
            end
            PH_ACCEL: begin
                if (r_byte_pos == '0) begin
                    n_partial  = {{(ACCEL_W-BYTE_W){1'b0}}, i_data_byte};
                    n_byte_pos = POS_W'(1);
                end else begin
                    n_byte_pos = '0;
                    n_partial  = '0;
                    if (r_value_idx >= ACCEL_LAST_IDX) begin
                        n_value_idx = '0;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_value_idx = r_value_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                // unknown codes behave like hunting
                n_phase = (i_data_byte == r_end_marker) ? PH_HEADER : PH_HUNT;
            end
        endcase
    end

    // result of this beat
    always_comb begin
        o_res_valid         = 1'b0;
        o_res.sample_kind   = KIND_EEG;
        o_res.channel_index = r_value_idx;
        o_res.sample_value  = {r_partial, i_data_byte};
        o_res.sample_number = r_counter;
        o_res.packet_last   = 1'b0;
        case (r_phase)
            PH_EEG: begin
                o_res_valid = i_accept && (r_byte_pos >= EEG_LAST_POS);
            end
            PH_ACCEL: begin
                o_res_valid        = i_accept && (r_byte_pos != '0);
                o_res.sample_kind  = KIND_ACCEL;
                o_res.sample_value = {{(VALUE_W-ACCEL_W){r_partial[BYTE_W-1]}},
                                      r_partial[BYTE_W-1:0], i_data_byte};
                o_res.packet_last  = (r_value_idx >= ACCEL_LAST_IDX);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_byte_pos      <= '0;
            r_value_idx     <= '0;
            r_partial       <= '0;
            r_counter       <= '0;
            r_end_marker    <= END_MARKER_RST;
            r_header_marker <= HEADER_MARKER_RST;
        end else begin
            if (i_accept) begin
                r_phase     <= n_phase;
                r_byte_pos  <= n_byte_pos;
                r_value_idx <= n_value_idx;
                r_partial   <= n_partial;
                r_counter   <= n_counter;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_END_MARKER:    r_end_marker    <= i_cfg_data;
                    CFG_HEADER_MARKER: r_header_marker <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ hdl/bpp_skid.sv @@
// ============================================================================
// bpp_skid
// output register with one skid entry, registered upstream ready
// ============================================================================
module bpp_skid
    import bpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_out_data  <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            // output stalled: park the new beat
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule

@@ hdl/biosignal_packet_parser_core.sv @@
// ============================================================================
// biosignal_packet_parser_core
// serial byte stream to sign-extended EEG and accelerometer samples
// ============================================================================
// output: a sample is registered as its last byte is accepted (skid entry on stall)
// throughput: one byte per cycle; ready drops only when both the output
//   register and the skid entry hold samples not yet taken downstream
// reset: synchronous active-low i_rst_n puts the parser in end-marker hunt,
//   restores the marker registers and empties the output stages
module biosignal_packet_parser_core
    import bpp_pkg::*;
#(
    parameter int EEG_CHANNELS = EEG_CHANNELS_DEF,
    parameter int ACCEL_AXES   = ACCEL_AXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes, only while idle
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // one serial byte per beat
    bpp_byte_if.sink             i_byte,
    // one decoded sample per beat
    bpp_sample_if.source         o_sample
);

    logic    w_ready;
    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    // a byte is taken whenever the skid entry is free
    assign i_byte.ready = w_ready;
    assign w_accept     = i_byte.valid && w_ready;

    // phase machine and value assembly
    bpp_parser #(
        .EEG_CHANNELS (EEG_CHANNELS),
        .ACCEL_AXES   (ACCEL_AXES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_data_byte (i_byte.data_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register plus skid entry decouples the two handshakes
    bpp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_ready),
        .o_valid (o_sample.valid),
        .o_data  (w_out),
        .i_ready (o_sample.ready)
    );

    assign o_sample.sample_kind   = w_out.sample_kind;
    assign o_sample.channel_index = w_out.channel_index;
    assign o_sample.sample_value  = w_out.sample_value;
    assign o_sample.sample_number = w_out.sample_number;
    assign o_sample.packet_last   = w_out.packet_last;

endmodule

@@ hdl/bpp_checker.sv @@
// ============================================================================
// bpp_checker
// port-level checks of the packet parser, bound to the top level
// ============================================================================
module bpp_checker
    import bpp_pkg::*;
#(
    parameter int EEG_CHANNELS = EEG_CHANNELS_DEF,
    parameter int ACCEL_AXES   = ACCEL_AXES_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_sample_kind,
    input logic [IDX_W-1:0]          i_channel_index,
    input logic signed [VALUE_W-1:0] i_sample_value,
    input logic                      i_packet_last
);

    localparam logic [IDX_W-1:0] ACCEL_LAST_IDX = IDX_W'(ACCEL_AXES - 1);
    localparam logic [IDX_W-1:0] EEG_LAST_IDX   = IDX_W'(EEG_CHANNELS - 1);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("sample valid right after reset");

    // input back-pressure only with a sample waiting
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    // end of packet only on the last accelerometer axis
    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_packet_last) |->
            (i_sample_kind == KIND_ACCEL) && (i_channel_index == ACCEL_LAST_IDX))
        else $error("packet end flag on wrong sample");

    // eeg channel number in range, accel values fit 16 bits
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_sample_kind == KIND_EEG) && (i_channel_index <= EEG_LAST_IDX)) ||
            ((i_sample_kind == KIND_ACCEL) && (i_channel_index <= ACCEL_LAST_IDX) &&
             (i_sample_value[VALUE_W-1:ACCEL_W-1] == '0 ||
              i_sample_value[VALUE_W-1:ACCEL_W-1] == '1)))
        else $error("sample index or accel extension out of range");

    // a stalled sample holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_sample_value) && $stable(i_channel_index))
        else $error("stalled sample changed");

endmodule

bind biosignal_packet_parser_core bpp_checker #(
    .EEG_CHANNELS (EEG_CHANNELS),
    .ACCEL_AXES   (ACCEL_AXES)
) u_bpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_byte.ready),
    .i_out_valid     (o_sample.valid),
    .i_out_ready     (o_sample.ready),
    .i_sample_kind   (o_sample.sample_kind),
    .i_channel_index (o_sample.channel_index),
    .i_sample_value  (o_sample.sample_value),
    .i_packet_last   (o_sample.packet_last)
);

@@ tb/testbench.sv @@
// ============================================================================
// testbench
// feeds serial bytes into the packet parser, follows the expected packet
// framing in a scoreboard and compares every decoded sample beat field by field
// ============================================================================
package bpp_tb_pkg;
    import bpp_pkg::*;

    class sample_scoreboard;
        // marker registers as last written
        logic [BYTE_W-1:0]  end_marker;
        logic [BYTE_W-1:0]  header_marker;
        // parser state
        t_phase             phase;
        logic [POS_W-1:0]   byte_pos;
        logic [IDX_W-1:0]   value_idx;
        logic [15:0]        partial;
        logic [BYTE_W-1:0]  packet_num;
        // decoded samples still owed by the block
        t_result            pending_samples [$];
        int                 error_count;

        function new();
            end_marker    = END_MARKER_RST;
            header_marker = HEADER_MARKER_RST;
            phase         = PH_HUNT;
            byte_pos      = '0;
            value_idx     = '0;
            partial       = '0;
            packet_num    = '0;
            error_count   = 0;
        endfunction

        function void set_marker(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
            case (index)
                CFG_END_MARKER:    end_marker = value;
                CFG_HEADER_MARKER: header_marker = value;
                default: ;
            endcase
        endfunction

        function void queue_sample(logic kind, logic [IDX_W-1:0] idx,
                                   logic [VALUE_W-1:0] value, logic last);
            t_result r;
            r.sample_kind   = kind;
            r.channel_index = idx;
            r.sample_value  = value;
            r.sample_number = packet_num;
            r.packet_last   = last;
            pending_samples.push_back(r);
        endfunction

        // advance the framing by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            logic last;
            case (phase)
                PH_HEADER: begin
                    // a wrong header byte is dropped, never tested as an end marker
                    phase = (b == header_marker) ? PH_COUNTER : PH_HUNT;
                end
                PH_COUNTER: begin
                    packet_num = b;
                    value_idx  = '0;
                    byte_pos   = '0;
                    phase      = PH_EEG;
                end
                PH_EEG: begin
                    if (byte_pos < 2) begin
                        partial  = {partial[7:0], b};
                        byte_pos = byte_pos + 1'b1;
                    end else begin
                        queue_sample(KIND_EEG, value_idx, {partial, b}, 1'b0);
                        byte_pos  = '0;
                        partial   = '0;
                        value_idx = value_idx + 1'b1;
                        if (value_idx == 0 || int'(value_idx) >= EEG_CHANNELS_DEF) begin
                            value_idx = '0;
                            phase     = PH_ACCEL;
                        end
                    end
                end
                PH_ACCEL: begin
                    if (byte_pos == 0) begin
                        partial  = {8'h00, b};
                        byte_pos = 2'd1;
                    end else begin
                        last = (int'(value_idx) + 1 >= ACCEL_AXES_DEF);
                        queue_sample(KIND_ACCEL, value_idx,
                                     {{8{partial[7]}}, partial[7:0], b}, last);
                        byte_pos = '0;
                        partial  = '0;
                        if (last) begin
                            value_idx = '0;
                            phase     = PH_HUNT;
                        end else begin
                            value_idx = value_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    phase = (b == end_marker) ? PH_HEADER : PH_HUNT;
                end
            endcase
        endfunction

        function void report(string what, t_result want, t_result got);
            error_count++;
            if (error_count <= 10) begin
                $write("%s: expected kind=%0d idx=%0d value=%0d num=%0d last=%0d, ",
                       what, want.sample_kind, want.channel_index, want.sample_value,
                       want.sample_number, want.packet_last);
                $display("got kind=%0d idx=%0d value=%0d num=%0d last=%0d",
                         got.sample_kind, got.channel_index, got.sample_value,
                         got.sample_number, got.packet_last);
            end
        endfunction

        function void check_sample(t_result got);
            t_result want;
            if (pending_samples.size() == 0) begin
                report("unexpected sample", '0, got);
                return;
            end
            want = pending_samples.pop_front();
            if (got.sample_kind !== want.sample_kind ||
                got.channel_index !== want.channel_index ||
                got.sample_value !== want.sample_value ||
                got.sample_number !== want.sample_number ||
                got.packet_last !== want.packet_last)
                report("sample mismatch", want, got);
        endfunction
    endclass
endpackage

module testbench;
    import bpp_pkg::*;
    import bpp_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    // settle margin that covers the sample register and the skid entry
    localparam int SETTLE_CYCLES = 4;
    // packet bytes per random phase, four phases
    localparam int PHASE_BYTES   = 280;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]  cfg_data;

    bpp_byte_if   byte_bus ();
    bpp_sample_if sample_bus ();

    sample_scoreboard results;

    // idling odds in percent, changed per phase
    int gap_pct   = 0;
    int stall_pct = 0;

    logic [BYTE_W-1:0] directed_bytes [$];

    biosignal_packet_parser_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_byte      (byte_bus),
        .o_sample    (sample_bus)
    );

    always #5 i_clk = ~i_clk;

    // one byte beat: random gap first, then hold valid until ready
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct) begin
            byte_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= b;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        // beat taken at this edge
        results.note_byte(b);
    endtask

    // hold off the sender until every owed sample has come out
    task automatic drain_samples();
        byte_bus.valid <= 1'b0;
        while (results.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both marker registers, back to back, only while idle
    task automatic write_markers(input logic [BYTE_W-1:0] end_val,
                                 input logic [BYTE_W-1:0] hdr_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_END_MARKER;
        cfg_data  <= end_val;
        @(posedge i_clk);
        results.set_marker(CFG_END_MARKER, end_val);
        cfg_index <= CFG_HEADER_MARKER;
        cfg_data  <= hdr_val;
        @(posedge i_clk);
        results.set_marker(CFG_HEADER_MARKER, hdr_val);
        cfg_we    <= 1'b0;
    endtask

    // payload byte biased toward markers and sign boundaries
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return results.end_marker;
            1:       return results.header_marker;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return 8'h80;
            5:       return 8'h7F;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: random stalls, every accepted sample beat goes to the scoreboard
    initial begin : receiver
        t_result got;
        sample_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sample_bus.valid && sample_bus.ready) begin
                got.sample_kind   = sample_bus.sample_kind;
                got.channel_index = sample_bus.channel_index;
                got.sample_value  = sample_bus.sample_value;
                got.sample_number = sample_bus.sample_number;
                got.packet_last   = sample_bus.packet_last;
                results.check_sample(got);
            end
            sample_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // cycle limit far above the slowest legal run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int                phase_idx;
        int                packet_bytes;
        int                n;
        logic [BYTE_W-1:0] end_val;
        logic [BYTE_W-1:0] hdr_val;
        logic [BYTE_W-1:0] junk;

        results = new();
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_END_MARKER;
        cfg_data           <= '0;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset markers: header mismatch where the dropped byte is
        // itself an end marker, a stray header while hunting, then one packet
        // with sign extremes and marker values inside the payload
        directed_bytes = '{
            8'hC0, 8'hC0, 8'hA0,
            8'hC0, 8'hA0, 8'hFF,
            8'h7F, 8'hFF, 8'hFF,
            8'h80, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00,
            8'hC0, 8'hA0, 8'hC0,
            8'hA5, 8'h5A, 8'h01,
            8'h00, 8'h00, 8'h01,
            8'h12, 8'h34, 8'h56,
            8'h7F, 8'hFF,
            8'h80, 8'h00,
            8'hFF, 8'hFF
        };
        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        drain_samples();

        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            // marker settings and idling mix per phase
            case (phase_idx)
                0: begin
                    end_val = 8'h00; hdr_val = 8'hFF;
                    gap_pct = 0;     stall_pct = 0;
                end
                1: begin
                    end_val = 8'hFF; hdr_val = 8'h00;
                    gap_pct = 57;    stall_pct = 0;
                end
                2: begin
                    // equal markers
                    end_val = 8'h5A; hdr_val = 8'h5A;
                    gap_pct = 0;     stall_pct = 57;
                end
                default: begin
                    end_val = BYTE_W'($urandom_range(0, 255));
                    hdr_val = BYTE_W'($urandom_range(0, 255));
                    gap_pct = 7;     stall_pct = 7;
                end
            endcase
            write_markers(end_val, hdr_val);

            packet_bytes = 0;
            while (packet_bytes < PHASE_BYTES) begin
                case ($urandom_range(0, 7))
                    0: begin
                        // broken start: end marker then a wrong header
                        junk = BYTE_W'($urandom_range(0, 255));
                        if (junk == results.header_marker) junk = junk ^ 8'h01;
                        send_byte(results.end_marker);
                        send_byte(junk);
                    end
                    1: begin
                        // line noise, may start or break a frame on its own
                        n = $urandom_range(1, 3);
                        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
                    end
                    default: begin
                        // well-formed packet with random content
                        send_byte(results.end_marker);
                        send_byte(results.header_marker);
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                        repeat (3 * EEG_CHANNELS_DEF + 2 * ACCEL_AXES_DEF)
                            send_byte(payload_byte());
                        packet_bytes += 3 + 3 * EEG_CHANNELS_DEF + 2 * ACCEL_AXES_DEF;
                    end
                endcase
            end
            // sender waits for every owed sample before the next setting
            drain_samples();
        end

        if (results.error_count == 0 && results.pending_samples.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
